// ===== sv/vsrs_pkg.sv =====
// Shared types and constants for the vital-sign running statistics block.
package vsrs_pkg;

   // Field and channel geometry.
   localparam int SAMPLE_BITS = 16;
   localparam int CHANNELS    = 3;

   // Window length register.
   localparam int CFG_BITS = 5;
   localparam logic [CFG_BITS-1:0] WINDOW_RESET = 5'd5;

   // Default ring depth; the top level hands its parameter down from here.
   localparam int DEFAULT_MAX_WINDOW = 16;

   // Front-to-back queue depth.
   localparam int QUEUE_DEPTH = 2;

   // Register port geometry. Bit 2 of the address selects the register.
   localparam int DATA_BITS = 32;
   localparam int ADDR_BITS = 3;
   localparam logic [ADDR_BITS-3:0] REG_WINDOW_LENGTH = 1'b0;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   // One sample per channel: index 0 temperature, 1 pulse rate, 2 SpO2.
   typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] samples_type;

   typedef struct packed {
      sample_type temperature;
      sample_type pulse_rate;
      sample_type oxygen_saturation;
   } req_item_type;

   typedef struct packed {
      sample_type max_temperature;
      sample_type max_pulse_rate;
      sample_type max_oxygen_saturation;
      sample_type min_temperature;
      sample_type min_pulse_rate;
      sample_type min_oxygen_saturation;
      sample_type avg_temperature;
      sample_type avg_pulse_rate;
      sample_type avg_oxygen_saturation;
      logic       average_valid;
   } rsp_item_type;

   // An item after the front has folded it into the running extrema.
   typedef struct packed {
      samples_type samples;
      samples_type maxima;
      samples_type minima;
   } queue_entry_type;

   // Register write toward the back.
   typedef struct packed {
      logic                write;
      logic [CFG_BITS-1:0] value;
   } cfg_write_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_RETIRE
   } back_state_type;

endpackage

// ===== sv/vsrs_front.sv =====
// Front of the block: accepts items, updates running extrema and queues the items.
module vsrs_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  vsrs_pkg::req_item_type    req_item,
   output logic                      queue_valid,
   input  logic                      queue_pop,
   output vsrs_pkg::queue_entry_type queue_head
);
   import vsrs_pkg::*;

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   samples_type max_ff, max_in;
   samples_type min_ff, min_in;
   samples_type sample;

   queue_entry_type entry_ff [QUEUE_DEPTH];

   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  push;
   logic                  pop;

   // Queue status and handshake.
   assign req_stall   = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign queue_valid = (count_ff != '0);
   assign push        = req_valid && !req_stall;
   assign pop         = queue_pop && queue_valid;
   assign queue_head  = entry_ff[rd_ptr_ff];

   assign sample[0] = req_item.temperature;
   assign sample[1] = req_item.pulse_rate;
   assign sample[2] = req_item.oxygen_saturation;

   // Running extrema move only when an item is taken.
   always_comb begin
      max_in = max_ff;
      min_in = min_ff;
      if (push) begin
         for (int c = 0; c < CHANNELS; c++) begin
            if (sample[c] > max_ff[c]) begin
               max_in[c] = sample[c];
            end
            if (sample[c] < min_ff[c]) begin
               min_in[c] = sample[c];
            end
         end
      end
   end

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + COUNT_BITS'(push) - COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff    <= '0;
         min_ff    <= '1;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         max_ff    <= max_in;
         min_ff    <= min_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage carries the sample together with the extrema it produced.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{samples: sample, maxima: max_in, minima: min_in};
      end
   end

endmodule

// ===== sv/vsrs_div.sv =====
// Serial restoring divider: three window sums by the window length, one bit per cycle.
module vsrs_div #(
   parameter int SUM_BITS = vsrs_pkg::SAMPLE_BITS + $clog2(vsrs_pkg::DEFAULT_MAX_WINDOW),
   parameter int LEN_BITS = $clog2(vsrs_pkg::DEFAULT_MAX_WINDOW + 1)
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   input  logic [vsrs_pkg::CHANNELS-1:0][SUM_BITS-1:0] dividend,
   input  logic [LEN_BITS-1:0]                        divisor,
   output logic                                       busy,
   output vsrs_pkg::samples_type                      quotient
);
   import vsrs_pkg::*;

   localparam int STEP_BITS = $clog2(SUM_BITS + 1);

   logic [CHANNELS-1:0][SUM_BITS-1:0] quot_ff, quot_in;
   logic [CHANNELS-1:0][LEN_BITS-1:0] rem_ff, rem_in;
   logic [LEN_BITS-1:0]               divisor_ff, divisor_in;
   logic [STEP_BITS-1:0]              step_ff, step_in;
   logic                              busy_ff, busy_in;

   assign busy = busy_ff;

   // The quotient fits the sample width because the sum never exceeds length times a sample.
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         quotient[c] = quot_ff[c][SAMPLE_BITS-1:0];
      end
   end

   // One restoring step per lane: the dividend shifts out as quotient bits shift in.
   always_comb begin
      logic [LEN_BITS:0] trial;
      logic [LEN_BITS:0] diff;
      logic              fits;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      trial      = '0;
      diff       = '0;
      fits       = 1'b0;
      if (start) begin
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         step_in    = STEP_BITS'(SUM_BITS);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         for (int c = 0; c < CHANNELS; c++) begin
            trial      = {rem_ff[c], quot_ff[c][SUM_BITS-1]};
            diff       = trial - {1'b0, divisor_ff};
            fits       = (trial >= {1'b0, divisor_ff});
            rem_in[c]  = fits ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
            quot_in[c] = {quot_ff[c][SUM_BITS-2:0], fits};
         end
         step_in = step_ff - 1'b1;
         busy_in = (step_ff != STEP_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

endmodule

// ===== sv/vsrs_back.sv =====
// Back of the block: sample ring, window sums, averaging sequence and result register.
module vsrs_back #(
   parameter int MAX_WINDOW = vsrs_pkg::DEFAULT_MAX_WINDOW
) (
   input  logic                            clock,
   input  logic                            reset,
   input  vsrs_pkg::cfg_write_type         cfg,
   output logic [vsrs_pkg::CFG_BITS-1:0]   window_length,
   input  logic                            queue_valid,
   output logic                            queue_pop,
   input  vsrs_pkg::queue_entry_type       queue_head,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output vsrs_pkg::rsp_item_type          rsp_item
);
   import vsrs_pkg::*;

   localparam int PTR_BITS = $clog2(MAX_WINDOW);
   localparam int LEN_BITS = $clog2(MAX_WINDOW + 1);
   localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam logic [LEN_BITS:0] DEPTH_WIDE = (LEN_BITS + 1)'(MAX_WINDOW);

   back_state_type state_ff, state_in;

   logic [CFG_BITS-1:0]               length_ff, length_in;
   logic [CHANNELS-1:0][SUM_BITS-1:0] sums_ff, sums_in;
   logic [LEN_BITS-1:0]               fill_ff, fill_in;
   logic [PTR_BITS-1:0]               oldest_ff, oldest_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              avg_valid_ff, avg_valid_in;
   samples_type                       max_hold_ff, max_hold_in;
   samples_type                       min_hold_ff, min_hold_in;
   rsp_item_type                      rsp_item_ff, rsp_item_in;
   samples_type                       old_ff;
   samples_type                       ring_mem [MAX_WINDOW];

   logic [LEN_BITS-1:0] eff_len;
   logic [LEN_BITS-1:0] fill_plus;
   logic [LEN_BITS:0]   slot_wide;
   logic [PTR_BITS-1:0] slot;
   logic                mem_we;
   logic                div_start;
   logic                div_busy;
   samples_type         quotient;

   assign window_length = length_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_item      = rsp_item_ff;

   // A length of zero counts as one; lengths beyond the ring saturate to its depth.
   always_comb begin
      if (length_ff == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (32'(length_ff) > 32'(MAX_WINDOW)) begin
         eff_len = LEN_BITS'(MAX_WINDOW);
      end else begin
         eff_len = LEN_BITS'(length_ff);
      end
   end

   // Next free ring slot sits fill entries past the oldest one.
   always_comb begin
      slot_wide = {1'b0, LEN_BITS'(oldest_ff)} + {1'b0, fill_ff};
      if (slot_wide >= DEPTH_WIDE) begin
         slot_wide = slot_wide - DEPTH_WIDE;
      end
      slot = slot_wide[PTR_BITS-1:0];
   end

   assign fill_plus = fill_ff + LEN_BITS'(1);

   // Averaging sequence: load, divide, retire.
   always_comb begin
      state_in     = state_ff;
      length_in    = length_ff;
      sums_in      = sums_ff;
      fill_in      = fill_ff;
      oldest_in    = oldest_ff;
      rsp_valid_in = rsp_valid_ff;
      avg_valid_in = avg_valid_ff;
      max_hold_in  = max_hold_ff;
      min_hold_in  = min_hold_ff;
      rsp_item_in  = rsp_item_ff;
      queue_pop    = 1'b0;
      mem_we       = 1'b0;
      div_start    = 1'b0;

      // The result register empties when its item is taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         BACK_IDLE: begin
            if (queue_valid) begin
               queue_pop    = 1'b1;
               mem_we       = 1'b1;
               div_start    = 1'b1;
               for (int c = 0; c < CHANNELS; c++) begin
                  sums_in[c] = sums_ff[c] + SUM_BITS'(queue_head.samples[c]);
               end
               fill_in      = fill_plus;
               avg_valid_in = (fill_plus >= eff_len);
               max_hold_in  = queue_head.maxima;
               min_hold_in  = queue_head.minima;
               state_in     = BACK_DIVIDE;
            end
         end
         BACK_DIVIDE: begin
            if (!div_busy) begin
               state_in = BACK_RETIRE;
            end
         end
         BACK_RETIRE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                      = 1'b1;
               rsp_item_in.max_temperature       = max_hold_ff[0];
               rsp_item_in.max_pulse_rate        = max_hold_ff[1];
               rsp_item_in.max_oxygen_saturation = max_hold_ff[2];
               rsp_item_in.min_temperature       = min_hold_ff[0];
               rsp_item_in.min_pulse_rate        = min_hold_ff[1];
               rsp_item_in.min_oxygen_saturation = min_hold_ff[2];
               rsp_item_in.avg_temperature       = avg_valid_ff ? quotient[0] : '0;
               rsp_item_in.avg_pulse_rate        = avg_valid_ff ? quotient[1] : '0;
               rsp_item_in.avg_oxygen_saturation = avg_valid_ff ? quotient[2] : '0;
               rsp_item_in.average_valid         = avg_valid_ff;
               // A full window drops its oldest sample.
               if (avg_valid_ff) begin
                  for (int c = 0; c < CHANNELS; c++) begin
                     sums_in[c] = sums_ff[c] - SUM_BITS'(old_ff[c]);
                  end
                  oldest_in = (oldest_ff == PTR_BITS'(MAX_WINDOW - 1)) ? '0
                                                                      : oldest_ff + 1'b1;
                  fill_in   = fill_ff - LEN_BITS'(1);
               end
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase

      // A length write restarts the window; write only while the block is idle (not enforced).
      if (cfg.write) begin
         length_in = cfg.value;
         sums_in   = '0;
         fill_in   = '0;
         oldest_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         length_ff    <= WINDOW_RESET;
         sums_ff      <= '0;
         fill_ff      <= '0;
         oldest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         sums_ff      <= sums_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      avg_valid_ff <= avg_valid_in;
      max_hold_ff  <= max_hold_in;
      min_hold_ff  <= min_hold_in;
      rsp_item_ff  <= rsp_item_in;
   end

   // Sample ring: written on load, oldest entry read back while the divider runs.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[slot] <= queue_head.samples;
      end
      old_ff <= ring_mem[oldest_ff];
   end

   vsrs_div #(
      .SUM_BITS (SUM_BITS),
      .LEN_BITS (LEN_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sums_in),
      .divisor  (eff_len),
      .busy     (div_busy),
      .quotient (quotient)
   );

endmodule

// ===== sv/vital_sign_running_stats_core.sv =====
// Top level of the vital-sign running statistics block.
//
//   Channel   Direction   Handshake                  Carries
//   req_*     in          req_valid / req_stall      one sample triple
//   rsp_*     out         rsp_valid / rsp_stall      extrema, averages, average_valid
//   p*        in / out    psel, penable, pready      window_length register
//
// An item goes from the queue head to the result register through the load, divide and
// retire states; the serial divider works out one quotient bit a cycle.
// Reset is synchronous and active high; the sample ring itself is not cleared.
// A two-entry queue takes items while the back works, and the result register
// holds its item under rsp_stall while the back finishes the next one.
module vital_sign_running_stats_core #(
   parameter int MAX_WINDOW = vsrs_pkg::DEFAULT_MAX_WINDOW
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  vsrs_pkg::req_item_type         req_item,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output vsrs_pkg::rsp_item_type         rsp_item,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [vsrs_pkg::ADDR_BITS-1:0] paddr,
   input  logic [vsrs_pkg::DATA_BITS-1:0] pwdata,
   output logic [vsrs_pkg::DATA_BITS-1:0] prdata,
   output logic                           pready
);
   import vsrs_pkg::*;

   queue_entry_type     queue_head;
   logic                queue_valid;
   logic                queue_pop;
   cfg_write_type       cfg;
   logic [CFG_BITS-1:0] window_length;
   logic                reg_hit;

   // Register port decode.
   assign pready    = 1'b1;
   assign reg_hit   = (paddr[ADDR_BITS-1:2] == REG_WINDOW_LENGTH);
   assign cfg.write = psel && penable && pwrite && reg_hit;
   assign cfg.value = pwdata[CFG_BITS-1:0];
   assign prdata    = reg_hit ? DATA_BITS'(window_length) : '0;

   vsrs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .queue_valid (queue_valid),
      .queue_pop   (queue_pop),
      .queue_head  (queue_head)
   );

   vsrs_back #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .window_length (window_length),
      .queue_valid   (queue_valid),
      .queue_pop     (queue_pop),
      .queue_head    (queue_head),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_item      (rsp_item)
   );

endmodule

// ===== sv/vsrs_checker.sv =====
// Port-level checks on the running statistics results, bound to the top level.
module vsrs_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input vsrs_pkg::rsp_item_type rsp_item
);
   import vsrs_pkg::*;

   // Every result follows at least one sample, so each maximum is at least its minimum.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.max_temperature >= rsp_item.min_temperature) &&
                    (rsp_item.max_pulse_rate >= rsp_item.min_pulse_rate) &&
                    (rsp_item.max_oxygen_saturation >= rsp_item.min_oxygen_saturation))
   else $error("maximum below minimum in a result item");

   // A window mean lies between the extrema seen since reset.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.average_valid |->
         (rsp_item.avg_temperature >= rsp_item.min_temperature) &&
         (rsp_item.avg_temperature <= rsp_item.max_temperature) &&
         (rsp_item.avg_pulse_rate >= rsp_item.min_pulse_rate) &&
         (rsp_item.avg_pulse_rate <= rsp_item.max_pulse_rate) &&
         (rsp_item.avg_oxygen_saturation >= rsp_item.min_oxygen_saturation) &&
         (rsp_item.avg_oxygen_saturation <= rsp_item.max_oxygen_saturation))
   else $error("window mean outside the running extrema");

   // Averages read zero while the window is not yet full.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.average_valid |->
         (rsp_item.avg_temperature == '0) && (rsp_item.avg_pulse_rate == '0) &&
         (rsp_item.avg_oxygen_saturation == '0))
   else $error("nonzero average without a full window");

   // A stalled result item stays in place.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
   else $error("result item changed under stall");

endmodule

bind vital_sign_running_stats_core vsrs_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

// ===== sim/tb_vital_sign_running_stats_core.sv =====
// Self-checking testbench for the vital-sign running extrema and moving average core.
`timescale 1ns / 1ps

module tb_vital_sign_running_stats_core;
   import vsrs_pkg::*;

   localparam int RING_DEPTH     = DEFAULT_MAX_WINDOW;
   localparam int SUM_BITS       = 20;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int LONG_HOLD      = 300;
   localparam int MAX_REPORTS    = 10;
   localparam int PHASE_ITEMS    = 90;
   localparam int PRESSURE_ITEMS = 60;

   localparam logic [ADDR_BITS-1:0] WINDOW_LENGTH_ADDR = {REG_WINDOW_LENGTH, 2'b00};
   localparam logic [ADDR_BITS-1:0] UNMAPPED_ADDR      = {~REG_WINDOW_LENGTH, 2'b00};

   // One pending input item with the idle cycles that precede it.
   typedef struct {
      req_item_type item;
      int unsigned  gap;
      bit           drain;
   } pending_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_item_type         req_item  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_item_type         rsp_item;
   logic                 psel      = 1'b0;
   logic                 penable   = 1'b0;
   logic                 pwrite    = 1'b0;
   logic [ADDR_BITS-1:0] paddr     = '0;
   logic [DATA_BITS-1:0] pwdata    = '0;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;

   // Shadow copy of the block's statistics state.
   logic [CFG_BITS-1:0]  cfg_window;
   sample_type           peak [CHANNELS];
   sample_type           trough [CHANNELS];
   sample_type           ring [RING_DEPTH][CHANNELS];
   logic [SUM_BITS-1:0]  window_total [CHANNELS];
   int                   ring_fill;
   int                   ring_oldest;

   pending_type          pending_items [$];
   rsp_item_type         stats_expected [$];

   int unsigned          send_gap_max = 0;
   int unsigned          stall_max    = 0;
   bit                   hold_go      = 1'b0;
   logic                 long_hold    = 1'b0;
   int                   mismatch_count = 0;
   int                   results_seen   = 0;
   int                   cycle_count    = 0;

   vital_sign_running_stats_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL vital_sign_running_stats_core");
         $finish;
      end
   end

   // Fold one accepted sample triple into the shadow state and queue the expected stats.
   task predict_stats(input req_item_type item);
      sample_type   s [CHANNELS];
      sample_type   avg [CHANNELS];
      rsp_item_type want;
      int           len;
      int           slot;
      logic         full;
      s[0] = item.temperature;
      s[1] = item.pulse_rate;
      s[2] = item.oxygen_saturation;
      if (cfg_window == 0) begin
         len = 1;
      end else if (cfg_window > RING_DEPTH) begin
         len = RING_DEPTH;
      end else begin
         len = cfg_window;
      end
      slot = (ring_oldest + ring_fill) % RING_DEPTH;
      for (int c = 0; c < CHANNELS; c++) begin
         if (s[c] > peak[c]) peak[c] = s[c];
         if (s[c] < trough[c]) trough[c] = s[c];
         ring[slot][c] = s[c];
         window_total[c] = window_total[c] + s[c];
      end
      ring_fill++;
      full = (ring_fill >= len);
      for (int c = 0; c < CHANNELS; c++) begin
         avg[c] = full ? sample_type'(window_total[c] / len) : '0;
      end
      want.max_temperature       = peak[0];
      want.max_pulse_rate        = peak[1];
      want.max_oxygen_saturation = peak[2];
      want.min_temperature       = trough[0];
      want.min_pulse_rate        = trough[1];
      want.min_oxygen_saturation = trough[2];
      want.avg_temperature       = avg[0];
      want.avg_pulse_rate        = avg[1];
      want.avg_oxygen_saturation = avg[2];
      want.average_valid         = full;
      // A full window drops its oldest sample after the average is taken.
      if (full) begin
         for (int c = 0; c < CHANNELS; c++) begin
            window_total[c] = window_total[c] - ring[ring_oldest][c];
         end
         ring_oldest = (ring_oldest + 1) % RING_DEPTH;
         ring_fill--;
      end
      stats_expected.insert(stats_expected.size(), want);
   endtask

   // A window length write clears the window but keeps the extrema.
   task load_window_length(input logic [CFG_BITS-1:0] value);
      cfg_window  = value;
      ring_fill   = 0;
      ring_oldest = 0;
      for (int c = 0; c < CHANNELS; c++) begin
         window_total[c] = '0;
      end
   endtask

   function void check_field(input string field, input logic [SAMPLE_BITS-1:0] want,
                             input logic [SAMPLE_BITS-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) begin
            $display("result %0d: %s expected %h, got %h", results_seen, field, want, got);
         end
      end
   endfunction

   // Request driver: takes pending items in order, honors per-item gaps and drain pauses.
   always @(posedge clock) begin : drive_requests
      pending_type next;
      bit          taken;
      bit          offer;
      int unsigned send_idle;
      if (reset) begin
         req_valid <= 1'b0;
         send_idle = 0;
      end else begin
         taken = req_valid && !req_stall;
         if (taken) predict_stats(req_item);
         offer = req_valid && !taken;
         if (!offer && pending_items.size() > 0) begin
            if (send_idle < pending_items[0].gap) begin
               send_idle++;
            end else if (!pending_items[0].drain || stats_expected.size() == 0) begin
               next = pending_items[0];
               pending_items.delete(0);
               req_item <= next.item;
               offer = 1'b1;
               send_idle = 0;
            end
         end
         req_valid <= offer;
      end
   end

   // Result monitor: checks every accepted item and draws the next stall.
   always @(posedge clock) begin : watch_results
      rsp_item_type want;
      int unsigned  rsp_wait;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (stats_expected.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("result %0d: no item expected, got %h", results_seen, rsp_item);
               end
            end else begin
               want = stats_expected[0];
               stats_expected.delete(0);
               check_field("max_temperature", want.max_temperature, rsp_item.max_temperature);
               check_field("max_pulse_rate", want.max_pulse_rate, rsp_item.max_pulse_rate);
               check_field("max_oxygen_saturation", want.max_oxygen_saturation,
                           rsp_item.max_oxygen_saturation);
               check_field("min_temperature", want.min_temperature, rsp_item.min_temperature);
               check_field("min_pulse_rate", want.min_pulse_rate, rsp_item.min_pulse_rate);
               check_field("min_oxygen_saturation", want.min_oxygen_saturation,
                           rsp_item.min_oxygen_saturation);
               check_field("avg_temperature", want.avg_temperature, rsp_item.avg_temperature);
               check_field("avg_pulse_rate", want.avg_pulse_rate, rsp_item.avg_pulse_rate);
               check_field("avg_oxygen_saturation", want.avg_oxygen_saturation,
                           rsp_item.avg_oxygen_saturation);
               check_field("average_valid", SAMPLE_BITS'(want.average_valid),
                           SAMPLE_BITS'(rsp_item.average_valid));
            end
            results_seen++;
            rsp_wait = $urandom_range(stall_max, 0);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_stall <= long_hold || (rsp_wait > 0);
      end
   end

   // Long receiver hold-off so the input queue fills and the block stalls its input.
   initial begin
      wait (hold_go);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      long_hold <= 1'b0;
   end

   task automatic queue_item(input sample_type t, input sample_type p, input sample_type o,
                             input bit drain);
      pending_type e;
      e.item.temperature       = t;
      e.item.pulse_rate        = p;
      e.item.oxygen_saturation = o;
      e.gap   = $urandom_range(send_gap_max, 0);
      e.drain = drain;
      pending_items.insert(pending_items.size(), e);
   endtask

   // Random sample around mid-scale; the spread grows so the extrema keep moving.
   function automatic sample_type draw_sample(input int spread);
      int lo;
      int hi;
      lo = 32768 - spread;
      hi = 32767 + spread;
      if (lo < 0) lo = 0;
      if (hi > 65535) hi = 65535;
      return sample_type'($urandom_range(hi, lo));
   endfunction

   task automatic wait_idle();
      while (pending_items.size() != 0 || req_valid || stats_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == WINDOW_LENGTH_ADDR) load_window_length(value[CFG_BITS-1:0]);
   endtask

   task automatic csr_check();
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= WINDOW_LENGTH_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[CFG_BITS-1:0] !== cfg_window) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) begin
            $display("window_length read: expected %0d, got %h", cfg_window, prdata);
         end
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin : stimulus
      logic [CFG_BITS-1:0] extremes [6];
      logic [CFG_BITS-1:0] length;
      extremes = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2};

      // Shadow state after reset.
      cfg_window = WINDOW_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
         peak[c]   = '0;
         trough[c] = '1;
      end
      load_window_length(WINDOW_RESET);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      csr_check();

      // Directed: first sample after reset, the window filling at the reset length.
      queue_item(16'h8000, 16'h8000, 16'h8000, 1'b0);
      queue_item(16'h8100, 16'h7F00, 16'h8000, 1'b0);
      queue_item(16'h7E00, 16'h8200, 16'h8001, 1'b0);
      queue_item(16'h8300, 16'h7C00, 16'h7FFF, 1'b1);
      queue_item(16'h8001, 16'h8001, 16'h8001, 1'b0);
      queue_item(16'h7000, 16'h9000, 16'h8800, 1'b0);
      wait_idle();

      // A write to an unmapped register leaves the window length alone.
      csr_write(UNMAPPED_ADDR, 32'd9);
      csr_check();

      // Random phases over a range of window lengths and idle patterns.
      for (int p = 0; p < 12; p++) begin
         length = (p < 6) ? extremes[p] : CFG_BITS'($urandom_range(31, 0));
         csr_write(WINDOW_LENGTH_ADDR, DATA_BITS'(length));
         csr_check();
         case (p % 3)
            0: begin
               send_gap_max = 0;
               stall_max    = 0;
            end
            1: begin
               send_gap_max = 16;
               stall_max    = 16;
            end
            default: begin
               send_gap_max = 4;
               stall_max    = 16;
            end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            queue_item(draw_sample((p + 1) * 2800), draw_sample((p + 1) * 2800),
                       draw_sample((p + 1) * 2800), ($urandom_range(99, 0) < 3));
         end
         wait_idle();
      end

      // Back-pressure: receiver holds off while the sender keeps offering.
      csr_write(WINDOW_LENGTH_ADDR, 32'd4);
      send_gap_max = 0;
      stall_max    = 0;
      hold_go      = 1'b1;
      for (int i = 0; i < PRESSURE_ITEMS; i++) begin
         queue_item(draw_sample(40000), draw_sample(40000), draw_sample(40000), 1'b0);
      end
      wait_idle();

      // Directed: largest window filled with full-scale samples, the largest sum.
      csr_write(WINDOW_LENGTH_ADDR, 32'd16);
      send_gap_max = 2;
      stall_max    = 2;
      for (int i = 0; i < RING_DEPTH; i++) begin
         queue_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      end
      wait_idle();

      // Directed: zero length acts as one, upper data bits are ignored.
      csr_write(WINDOW_LENGTH_ADDR, 32'hFFFF_FFE0);
      csr_check();
      queue_item(16'h0000, 16'h0000, 16'h0000, 1'b0);
      queue_item(16'hAAAA, 16'h5555, 16'h0001, 1'b0);
      queue_item(16'h5555, 16'hAAAA, 16'hFFFE, 1'b0);
      wait_idle();

      if (mismatch_count == 0 && stats_expected.size() == 0) begin
         $display("PASS vital_sign_running_stats_core");
      end else begin
         $display("FAIL vital_sign_running_stats_core");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/vsrs_pkg.sv
sv/vsrs_front.sv
sv/vsrs_div.sv
sv/vsrs_back.sv
sv/vital_sign_running_stats_core.sv
sv/vsrs_checker.sv
sim/tb_vital_sign_running_stats_core.sv
